FILE: hdl/talu_pkg.sv
// Shared types, opcodes and a helper function for the Thumb ALU block.
`timescale 1ns / 1ps
`default_nettype none

package talu_pkg;

    localparam int DATA_W = 32;
    localparam int CYC_W  = 3;

    // Instruction format
    localparam logic KIND_ALU = 1'b0;
    localparam logic KIND_IMM = 1'b1;

    // Register ALU opcodes
    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_LSL = 4'd2,
        OP_LSR = 4'd3,
        OP_ASR = 4'd4,
        OP_ADC = 4'd5,
        OP_SBC = 4'd6,
        OP_ROR = 4'd7,
        OP_TST = 4'd8,
        OP_NEG = 4'd9,
        OP_CMP = 4'd10,
        OP_CMN = 4'd11,
        OP_ORR = 4'd12,
        OP_MUL = 4'd13,
        OP_BIC = 4'd14,
        OP_MVN = 4'd15
    } alu_op_t;

    // Immediate shift opcodes; anything else passes the operand through
    localparam logic [3:0] IMM_LSL = 4'd0;
    localparam logic [3:0] IMM_LSR = 4'd1;
    localparam logic [3:0] IMM_ASR = 4'd2;

    // Barrel shifter function select
    typedef enum logic [1:0] {
        SHK_LSL,
        SHK_LSR,
        SHK_ASR,
        SHK_ROR
    } shift_kind_t;

    // Multiplier early-termination masks
    localparam logic [DATA_W-1:0] MUL_MASK1 = 32'hFFFF_FF00;
    localparam logic [DATA_W-1:0] MUL_MASK2 = 32'hFFFF_0000;
    localparam logic [DATA_W-1:0] MUL_MASK3 = 32'hFF00_0000;

    typedef struct packed {
        logic              kind;
        logic [3:0]        op;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic [4:0]        shift_imm;
        logic              carry_in;
        logic              overflow_in;
    } talu_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              write_back;
        logic              negative;
        logic              zero;
        logic              carry_out;
        logic              overflow_out;
        logic [CYC_W-1:0]  internal_cycles;
    } talu_rsp_t;

    // Multiply cycle count from the leading sign bytes of the multiplier
    function automatic logic [CYC_W-1:0] mul_cycles(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] m1;
        logic [DATA_W-1:0] m2;
        logic [DATA_W-1:0] m3;
        m1 = v & MUL_MASK1;
        m2 = v & MUL_MASK2;
        m3 = v & MUL_MASK3;
        if (m1 == MUL_MASK1 || m1 == '0)
            return CYC_W'(1);
        else if (m2 == MUL_MASK2 || m2 == '0)
            return CYC_W'(2);
        else if (m3 == MUL_MASK3 || m3 == '0)
            return CYC_W'(3);
        else
            return CYC_W'(4);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/talu_cmd_if.sv
// Command channel interface: valid/ready plus one instruction's operands.
`timescale 1ns / 1ps
`default_nettype none

interface talu_cmd_if import talu_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              kind;
    logic [3:0]        op;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
    logic [4:0]        shift_imm;
    logic              carry_in;
    logic              overflow_in;

    modport source (
        output valid, kind, op, operand_a, operand_b, shift_imm, carry_in, overflow_in,
        input  ready
    );

    modport sink (
        input  valid, kind, op, operand_a, operand_b, shift_imm, carry_in, overflow_in,
        output ready
    );

endinterface

`default_nettype wire

FILE: hdl/talu_rsp_if.sv
// Result channel interface: valid/ready plus result value and new flags.
`timescale 1ns / 1ps
`default_nettype none

interface talu_rsp_if import talu_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result;
    logic              write_back;
    logic              negative;
    logic              zero;
    logic              carry_out;
    logic              overflow_out;
    logic [CYC_W-1:0]  internal_cycles;

    modport source (
        output valid, result, write_back, negative, zero, carry_out, overflow_out,
               internal_cycles,
        input  ready
    );

    modport sink (
        input  valid, result, write_back, negative, zero, carry_out, overflow_out,
               internal_cycles,
        output ready
    );

endinterface

`default_nettype wire

FILE: hdl/talu_shifter.sv
// Barrel shifter with ARM shifter carry-out rules for LSL, LSR, ASR and ROR.
`timescale 1ns / 1ps
`default_nettype none

module talu_shifter import talu_pkg::*; (
    input  wire shift_kind_t       kind,
    input  wire logic [7:0]        amount,
    input  wire logic [DATA_W-1:0] value,
    input  wire logic              carry_in,
    output logic      [DATA_W-1:0] result,
    output logic                   carry_out
);

    logic              amt_zero;
    logic              amt_over;   // amount above 32
    logic              amt_big;    // amount 32 or above
    logic [5:0]        amt_clip;   // amount limited to 0..32
    logic [DATA_W:0]   lsl_ext;
    logic [DATA_W:0]   lsr_ext;
    logic [DATA_W:0]   asr_ext;
    logic [4:0]        rot;
    logic [2*DATA_W-1:0] rot_ext;
    logic [DATA_W-1:0] ror_val;

    assign amt_zero = (amount == 8'd0);
    assign amt_over = (amount > 8'd32);
    assign amt_big  = (amount >= 8'd32);
    assign amt_clip = amt_big ? 6'd32 : amount[5:0];

    // Extended shifts: the extra bit catches the last bit shifted out
    assign lsl_ext = {1'b0, value} << amt_clip;
    assign lsr_ext = {value, 1'b0} >> amt_clip;
    assign asr_ext = $signed({value, 1'b0}) >>> amt_clip;

    // Rotate by amount modulo 32; a whole turn leaves the value
    assign rot     = amount[4:0];
    assign rot_ext = {value, value} >> rot;
    assign ror_val = rot_ext[DATA_W-1:0];

    always_comb
    begin
        result    = value;
        carry_out = carry_in;
        if (!amt_zero)
        begin
            unique case (kind)
                SHK_LSL:
                begin
                    result    = amt_over ? '0 : lsl_ext[DATA_W-1:0];
                    carry_out = amt_over ? 1'b0 : lsl_ext[DATA_W];
                end
                SHK_LSR:
                begin
                    result    = amt_over ? '0 : lsr_ext[DATA_W:1];
                    carry_out = amt_over ? 1'b0 : lsr_ext[0];
                end
                SHK_ASR:
                begin
                    result    = asr_ext[DATA_W:1];
                    carry_out = asr_ext[0];
                end
                SHK_ROR:
                begin
                    result    = ror_val;
                    carry_out = ror_val[DATA_W-1];
                end
                default:
                begin
                    result    = value;
                    carry_out = carry_in;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/talu_datapath.sv
// Single-pass data path: logic, adder, multiplier, shifter and flag logic.
`timescale 1ns / 1ps
`default_nettype none

module talu_datapath import talu_pkg::*; (
    input  wire talu_cmd_t cmd,
    output talu_rsp_t      rsp
);

    shift_kind_t       sh_kind;
    logic [7:0]        sh_amount;
    logic [DATA_W-1:0] sh_result;
    logic              sh_carry;

    logic [DATA_W-1:0] add_x;
    logic [DATA_W-1:0] add_y;
    logic              add_cin;
    logic [DATA_W:0]   add_sum;
    logic              add_v;

    logic [2*DATA_W-1:0] mul_full;

    logic [DATA_W-1:0] res;
    logic              wb;
    logic              c_new;
    logic              v_new;
    logic [CYC_W-1:0]  cyc;

    // Shifter setup: register shifts use the low byte of operand_b,
    // immediate LSR/ASR by zero mean 32, other immediate codes pass through
    always_comb
    begin
        sh_kind   = SHK_LSL;
        sh_amount = 8'd0;
        if (cmd.kind == KIND_IMM)
        begin
            unique case (cmd.op)
                IMM_LSL:
                begin
                    sh_kind   = SHK_LSL;
                    sh_amount = {3'd0, cmd.shift_imm};
                end
                IMM_LSR:
                begin
                    sh_kind   = SHK_LSR;
                    sh_amount = (cmd.shift_imm == 5'd0) ? 8'd32 : {3'd0, cmd.shift_imm};
                end
                IMM_ASR:
                begin
                    sh_kind   = SHK_ASR;
                    sh_amount = (cmd.shift_imm == 5'd0) ? 8'd32 : {3'd0, cmd.shift_imm};
                end
                default:
                begin
                    sh_kind   = SHK_LSL;
                    sh_amount = 8'd0;
                end
            endcase
        end
        else
        begin
            sh_amount = cmd.operand_b[7:0];
            unique case (alu_op_t'(cmd.op))
                OP_LSR:  sh_kind = SHK_LSR;
                OP_ASR:  sh_kind = SHK_ASR;
                OP_ROR:  sh_kind = SHK_ROR;
                default: sh_kind = SHK_LSL;
            endcase
        end
    end

    talu_shifter u_shifter (
        .kind      (sh_kind),
        .amount    (sh_amount),
        .value     (cmd.operand_a),
        .carry_in  (cmd.carry_in),
        .result    (sh_result),
        .carry_out (sh_carry)
    );

    // Shared adder: subtraction as a + NOT b + carry
    always_comb
    begin
        add_x   = cmd.operand_a;
        add_y   = cmd.operand_b;
        add_cin = 1'b0;
        unique case (alu_op_t'(cmd.op))
            OP_ADC:
            begin
                add_cin = cmd.carry_in;
            end
            OP_SBC:
            begin
                add_y   = ~cmd.operand_b;
                add_cin = cmd.carry_in;
            end
            OP_NEG:
            begin
                add_x   = '0;
                add_y   = ~cmd.operand_b;
                add_cin = 1'b1;
            end
            OP_CMP:
            begin
                add_y   = ~cmd.operand_b;
                add_cin = 1'b1;
            end
            default:
            begin
                add_cin = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{DATA_W{1'b0}}, add_cin};
    assign add_v   = ~(add_x[DATA_W-1] ^ add_y[DATA_W-1])
                   & (add_x[DATA_W-1] ^ add_sum[DATA_W-1]);

    assign mul_full = cmd.operand_a * cmd.operand_b;

    // Result, write enable, C/V and internal cycle count selection
    always_comb
    begin
        res   = cmd.operand_a;
        wb    = 1'b1;
        c_new = cmd.carry_in;
        v_new = cmd.overflow_in;
        cyc   = '0;
        if (cmd.kind == KIND_IMM)
        begin
            res   = sh_result;
            c_new = sh_carry;
        end
        else
        begin
            unique case (alu_op_t'(cmd.op))
                OP_AND: res = cmd.operand_a & cmd.operand_b;
                OP_EOR: res = cmd.operand_a ^ cmd.operand_b;
                OP_LSL, OP_LSR, OP_ASR, OP_ROR:
                begin
                    res   = sh_result;
                    c_new = sh_carry;
                    cyc   = CYC_W'(1);
                end
                OP_ADC, OP_SBC, OP_NEG:
                begin
                    res   = add_sum[DATA_W-1:0];
                    c_new = add_sum[DATA_W];
                    v_new = add_v;
                end
                OP_CMP, OP_CMN:
                begin
                    res   = add_sum[DATA_W-1:0];
                    c_new = add_sum[DATA_W];
                    v_new = add_v;
                    wb    = 1'b0;
                end
                OP_TST:
                begin
                    res = cmd.operand_a & cmd.operand_b;
                    wb  = 1'b0;
                end
                OP_ORR: res = cmd.operand_a | cmd.operand_b;
                OP_MUL:
                begin
                    res = mul_full[DATA_W-1:0];
                    cyc = mul_cycles(cmd.operand_a);
                end
                OP_BIC: res = cmd.operand_a & ~cmd.operand_b;
                OP_MVN: res = ~cmd.operand_b;
                default: res = cmd.operand_a;
            endcase
        end
    end

    // Pack result, N/Z flags, C/V and internal cycle count
    always_comb
    begin
        rsp.result          = res;
        rsp.write_back      = wb;
        rsp.negative        = res[DATA_W-1];
        rsp.zero            = (res == '0);
        rsp.carry_out       = c_new;
        rsp.overflow_out    = v_new;
        rsp.internal_cycles = cyc;
    end

endmodule

`default_nettype wire

FILE: hdl/thumb_alu_with_flags.sv
// Top level: input register, single-pass data path and result register.
//
//  Port  Modport  Transaction
//  ----  -------  ---------------------------------------------------------
//  cmd   sink     kind, op, operand_a, operand_b, shift_imm, carry_in,
//                 overflow_in
//  rsp   source   result, write_back, negative, zero, carry_out,
//                 overflow_out, internal_cycles
//
//  A transaction is captured in the input register, passes the data path
//  (32x32 multiplier, 33-bit adder) and lands in the result register. One
//  transaction per cycle is sustained while rsp is not stalled. A stall
//  holds the result register and a full input register; cmd.ready is high
//  while the input register can load. Reset clears both valid bits.
`timescale 1ns / 1ps
`default_nettype none

module thumb_alu_with_flags import talu_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    talu_cmd_if.sink   cmd,
    talu_rsp_if.source rsp
);

    logic      in_valid_reg;
    talu_cmd_t in_data_reg;
    logic      out_valid_reg;
    talu_rsp_t out_data_reg;

    talu_cmd_t cmd_word;
    talu_rsp_t dp_rsp;
    logic      out_advance;
    logic      in_advance;

    // Stage handshakes
    assign out_advance = !out_valid_reg || rsp.ready;
    assign in_advance  = !in_valid_reg || out_advance;
    assign cmd.ready   = in_advance;

    always_comb
    begin
        cmd_word.kind        = cmd.kind;
        cmd_word.op          = cmd.op;
        cmd_word.operand_a   = cmd.operand_a;
        cmd_word.operand_b   = cmd.operand_b;
        cmd_word.shift_imm   = cmd.shift_imm;
        cmd_word.carry_in    = cmd.carry_in;
        cmd_word.overflow_in = cmd.overflow_in;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_advance)
                in_valid_reg <= cmd.valid;
            if (out_advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_advance && cmd.valid)
            in_data_reg <= cmd_word;
        if (out_advance && in_valid_reg)
            out_data_reg <= dp_rsp;
    end

    talu_datapath u_datapath (
        .cmd (in_data_reg),
        .rsp (dp_rsp)
    );

    // Result channel
    assign rsp.valid           = out_valid_reg;
    assign rsp.result          = out_data_reg.result;
    assign rsp.write_back      = out_data_reg.write_back;
    assign rsp.negative        = out_data_reg.negative;
    assign rsp.zero            = out_data_reg.zero;
    assign rsp.carry_out       = out_data_reg.carry_out;
    assign rsp.overflow_out    = out_data_reg.overflow_out;
    assign rsp.internal_cycles = out_data_reg.internal_cycles;

endmodule

`default_nettype wire
